FILE: sv/azc_pkg.sv
// Shared types, constants and register codes for the autofocus and zoom controller.
package azc_pkg;

    // Input request carried by one video frame.
    typedef struct packed {
        logic        target_detected;
        logic [15:0] sharpness;
        logic [9:0]  target_size;
    } azc_in_t;

    // Result produced for each frame.
    typedef struct packed {
        logic [9:0] focus_position;
        logic       focus_sent;
        logic [7:0] zoom_position;
        logic       zoom_sent;
        logic       zoom_changed;
        logic       in_scan;
    } azc_out_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FOCUS_LOW      = 3'd0,
        CFG_FOCUS_HIGH     = 3'd1,
        CFG_CLIMB_STEP     = 3'd2,
        CFG_SCAN_STEP      = 3'd3,
        CFG_SIZE_UPPER     = 3'd4,
        CFG_SIZE_LOWER     = 3'd5,
        CFG_ZOOM_TOP       = 3'd6,
        CFG_ZOOM_INCREMENT = 3'd7
    } cfg_index_t;

    // Configuration reset values.
    localparam logic [9:0] FOCUS_LOW_RESET      = 10'd650;
    localparam logic [9:0] FOCUS_HIGH_RESET     = 10'd800;
    localparam logic [5:0] CLIMB_STEP_RESET     = 6'd3;
    localparam logic [5:0] SCAN_STEP_RESET      = 6'd10;
    localparam logic [9:0] SIZE_UPPER_RESET     = 10'd30;
    localparam logic [9:0] SIZE_LOWER_RESET     = 10'd25;
    localparam logic [7:0] ZOOM_TOP_RESET       = 8'd171;
    localparam logic [4:0] ZOOM_INCREMENT_RESET = 5'd3;

    // Frame counter runs from 0 to FRAME_LAST and wraps.
    localparam logic [4:0] FRAME_LAST = 5'd23;
    // Zoom is adjusted when the counter modulo 8 hits this phase.
    localparam logic [2:0] ZOOM_PHASE = 3'd6;

    // Miss counter thresholds and saturation.
    localparam logic [5:0] MISS_RESCAN = 6'd15;
    localparam logic [5:0] MISS_LOST   = 6'd32;
    localparam logic [5:0] MISS_MAX    = 6'd63;

    // Filtered size after reset: 100.0 in Q10.8.
    localparam logic [17:0] SIZE_RESET = 18'd25600;
    localparam logic [9:0]  FOCUS_MAX  = 10'd1023;

    // Reciprocal of 5 scaled by 2^24, rounded up; exact for dividends below 2^22.
    localparam logic [21:0] DIV5_RECIP = 22'd3355444;
    localparam int          DIV5_SHIFT = 24;

    // Counter values that are multiples of the short (3) and long (6) periods.
    localparam logic [31:0] PHASE3_MASK = 32'h0024_9249;
    localparam logic [31:0] PHASE6_MASK = 32'h0004_1041;

endpackage

FILE: sv/autofocus_zoom_controller_unit.sv
// Each accepted request passes through the input register and then the result register.
// Throughput: one request per cycle while out_stall is low; the frame update is a single
// registered pass (one 21x22 reciprocal multiply for the size filter plus compares and adds).
// Reset (rst_n low, asynchronous) clears both pipeline stages, loads the default
// configuration and puts the controller in coarse scan mode with zoom at 171.
module autofocus_zoom_controller_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  azc_pkg::azc_in_t       in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output azc_pkg::azc_out_t      out_data,
    input  logic                   cfg_write,
    input  azc_pkg::cfg_index_t    cfg_index,
    input  logic [9:0]             cfg_data
);
    import azc_pkg::*;

    // Configuration registers.
    logic [9:0] focus_low_reg, focus_high_reg, size_upper_reg, size_lower_reg;
    logic [5:0] climb_step_reg, scan_step_reg;
    logic [7:0] zoom_top_reg;
    logic [4:0] zoom_increment_reg;

    // Pipeline registers.
    logic     s1_valid_reg;
    azc_in_t  s1_data_reg;
    logic     out_valid_reg;
    azc_out_t out_data_reg, out_data_next;
    logic     advance;

    // Controller state.
    logic [4:0]  frame_count_reg, frame_count_next;
    logic        long_period_reg, long_period_next;
    logic        seen_now_reg;
    logic        scanning_reg, scanning_next;
    logic        scan_start_reg, scan_start_next;
    logic        toward_far_reg, toward_far_next;
    logic        found_in_scan_reg, found_in_scan_next;
    logic [9:0]  best_focus_reg, best_focus_next;
    logic [15:0] best_sharpness_reg, best_sharpness_next;
    logic [15:0] sharp_now_reg, sharp_prev_next;
    logic [16:0] sum_prev_reg, sum_prev_next;
    logic [17:0] size_filtered_reg, size_filtered_next;
    logic [5:0]  miss_count_reg, miss_count_next;
    logic [9:0]  focus_reg, focus_next;
    logic [7:0]  zoom_reg, zoom_next;

    // Size filter: floor((4*filtered + size*256)/5) by reciprocal multiply.
    logic [20:0] size_sum;
    logic [42:0] size_prod;

    assign size_sum  = {1'b0, size_filtered_reg, 2'b00} + {3'b000, s1_data_reg.target_size, 8'h00};
    assign size_prod = {22'd0, size_sum} * {21'd0, DIV5_RECIP};
    assign size_filtered_next = size_prod[DIV5_SHIFT +: 18];

    // Handshake: stage 1 moves on whenever the result register is free or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Frame update.
    always_comb
    begin
        logic        det;
        logic        phase_zero;
        logic        focus_out;
        logic        zoom_out;
        logic [8:0]  zoom_up;
        logic [10:0] scan_next;
        logic [16:0] sum;
        logic signed [11:0] climb_f;

        det = s1_data_reg.target_detected;

        frame_count_next    = (frame_count_reg == FRAME_LAST) ? 5'd0 : frame_count_reg + 5'd1;
        long_period_next    = long_period_reg;
        scanning_next       = scanning_reg;
        scan_start_next     = scan_start_reg;
        toward_far_next     = toward_far_reg;
        found_in_scan_next  = found_in_scan_reg;
        best_focus_next     = best_focus_reg;
        best_sharpness_next = best_sharpness_reg;
        sum_prev_next       = sum_prev_reg;
        focus_next          = focus_reg;
        zoom_next           = zoom_reg;
        focus_out           = 1'b0;
        zoom_out            = 1'b0;
        zoom_up             = 9'd0;
        scan_next           = 11'd0;
        sum                 = 17'd0;
        climb_f             = 12'sd0;

        // The previous frame's sharpness counts only if the target was seen then.
        sharp_prev_next = (!seen_now_reg && det) ? 16'd0 : sharp_now_reg;

        if (det)
        begin
            miss_count_next = 6'd0;
        end
        else
        begin
            miss_count_next = (miss_count_reg < MISS_MAX) ? miss_count_reg + 6'd1 : MISS_MAX;
        end

        // A long miss while climbing restarts the scan.
        if (miss_count_next > MISS_RESCAN && !scanning_reg)
        begin
            scanning_next    = 1'b1;
            frame_count_next = 5'd0;
        end

        // Zoom: jump to the top when lost, else step at the zoom phase.
        if (!det)
        begin
            if (miss_count_next > MISS_LOST)
            begin
                zoom_next        = zoom_top_reg;
                zoom_out         = 1'b1;
                frame_count_next = 5'd0;
                miss_count_next  = 6'd0;
            end
        end
        else if (frame_count_next[2:0] == ZOOM_PHASE)
        begin
            if (size_filtered_next > {size_upper_reg, 8'h00})
            begin
                zoom_up   = {1'b0, zoom_reg} + {4'd0, zoom_increment_reg};
                zoom_next = (zoom_up < {1'b0, zoom_top_reg}) ? zoom_up[7:0] : zoom_top_reg;
                zoom_out  = 1'b1;
            end
            else if (size_filtered_next < {size_lower_reg, 8'h00})
            begin
                zoom_next = (zoom_reg > {3'd0, zoom_increment_reg})
                          ? zoom_reg - {3'd0, zoom_increment_reg} : 8'd0;
                zoom_out  = 1'b1;
            end
        end

        phase_zero = long_period_reg ? PHASE6_MASK[frame_count_next]
                                     : PHASE3_MASK[frame_count_next];

        // Focus: coarse scan, or hill climbing while the target is seen.
        if (scanning_next)
        begin
            if (scan_start_reg)
            begin
                if (phase_zero)
                begin
                    found_in_scan_next  = 1'b0;
                    best_sharpness_next = 16'd0;
                    long_period_next    = 1'b1;
                    focus_next          = focus_low_reg;
                    focus_out           = 1'b1;
                    scan_start_next     = 1'b0;
                end
            end
            else if (phase_zero)
            begin
                long_period_next = 1'b0;
                if (det && s1_data_reg.sharpness > best_sharpness_reg)
                begin
                    best_sharpness_next = s1_data_reg.sharpness;
                    best_focus_next     = focus_reg;
                    found_in_scan_next  = 1'b1;
                end
                scan_next = {1'b0, focus_reg} + {5'd0, scan_step_reg};
                if (scan_next > {1'b0, focus_high_reg})
                begin
                    if (found_in_scan_next)
                    begin
                        scan_next       = {1'b0, best_focus_next};
                        scanning_next   = 1'b0;
                        toward_far_next = 1'b1;
                    end
                    scan_start_next  = 1'b1;
                    frame_count_next = 5'd0;
                end
                focus_next = scan_next[10] ? FOCUS_MAX : scan_next[9:0];
                focus_out  = 1'b1;
            end
        end
        else if (det)
        begin
            if (phase_zero && seen_now_reg)
            begin
                sum = {1'b0, s1_data_reg.sharpness} + {1'b0, sharp_prev_next};
                if (sum < sum_prev_reg)
                begin
                    toward_far_next = !toward_far_reg;
                end
                if (toward_far_next)
                begin
                    climb_f = $signed({2'b00, focus_reg}) + $signed({6'd0, climb_step_reg});
                end
                else
                begin
                    climb_f = $signed({2'b00, focus_reg}) - $signed({6'd0, climb_step_reg});
                end
                if (climb_f > $signed({2'b00, focus_high_reg}))
                begin
                    climb_f = $signed({2'b00, focus_high_reg});
                end
                if (climb_f < $signed({2'b00, focus_low_reg}))
                begin
                    climb_f = $signed({2'b00, focus_low_reg});
                end
                focus_next    = climb_f[9:0];
                sum_prev_next = sum;
                focus_out     = 1'b1;
            end
        end

        out_data_next.focus_position = focus_next;
        out_data_next.focus_sent     = focus_out;
        out_data_next.zoom_position  = zoom_next;
        out_data_next.zoom_sent      = zoom_out;
        out_data_next.zoom_changed   = (zoom_next != zoom_reg);
        out_data_next.in_scan        = scanning_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_low_reg      <= FOCUS_LOW_RESET;
            focus_high_reg     <= FOCUS_HIGH_RESET;
            climb_step_reg     <= CLIMB_STEP_RESET;
            scan_step_reg      <= SCAN_STEP_RESET;
            size_upper_reg     <= SIZE_UPPER_RESET;
            size_lower_reg     <= SIZE_LOWER_RESET;
            zoom_top_reg       <= ZOOM_TOP_RESET;
            zoom_increment_reg <= ZOOM_INCREMENT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FOCUS_LOW:      focus_low_reg      <= cfg_data;
                CFG_FOCUS_HIGH:     focus_high_reg     <= cfg_data;
                CFG_CLIMB_STEP:     climb_step_reg     <= cfg_data[5:0];
                CFG_SCAN_STEP:      scan_step_reg      <= cfg_data[5:0];
                CFG_SIZE_UPPER:     size_upper_reg     <= cfg_data;
                CFG_SIZE_LOWER:     size_lower_reg     <= cfg_data;
                CFG_ZOOM_TOP:       zoom_top_reg       <= cfg_data[7:0];
                CFG_ZOOM_INCREMENT: zoom_increment_reg <= cfg_data[4:0];
            endcase
        end
    end

    // Input stage and result register valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_valid_reg && advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Controller state, updated once per frame as it moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg    <= 5'd0;
            long_period_reg    <= 1'b0;
            seen_now_reg       <= 1'b0;
            scanning_reg       <= 1'b1;
            scan_start_reg     <= 1'b1;
            toward_far_reg     <= 1'b1;
            found_in_scan_reg  <= 1'b0;
            best_focus_reg     <= 10'd0;
            best_sharpness_reg <= 16'd0;
            sharp_now_reg      <= 16'd0;
            sum_prev_reg       <= 17'd0;
            size_filtered_reg  <= SIZE_RESET;
            miss_count_reg     <= 6'd0;
            focus_reg          <= 10'd0;
            zoom_reg           <= ZOOM_TOP_RESET;
        end
        else if (s1_valid_reg && advance)
        begin
            frame_count_reg    <= frame_count_next;
            long_period_reg    <= long_period_next;
            seen_now_reg       <= s1_data_reg.target_detected;
            scanning_reg       <= scanning_next;
            scan_start_reg     <= scan_start_next;
            toward_far_reg     <= toward_far_next;
            found_in_scan_reg  <= found_in_scan_next;
            best_focus_reg     <= best_focus_next;
            best_sharpness_reg <= best_sharpness_next;
            sharp_now_reg      <= s1_data_reg.sharpness;
            sum_prev_reg       <= sum_prev_next;
            size_filtered_reg  <= size_filtered_next;
            miss_count_reg     <= miss_count_next;
            focus_reg          <= focus_next;
            zoom_reg           <= zoom_next;
        end
    end

endmodule

FILE: sv/azc_checker.sv
// Port-level checker for the autofocus and zoom controller, bound to the top level.
module azc_port_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  azc_pkg::azc_out_t   out_data
);
    import azc_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed while stalled");

    // The input side only backs up when the output side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with output free");

    // Every accepted request is followed by a result waiting on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("result missing after accepted request");

    // Zoom can only change when a zoom command goes out.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zoom_changed |-> out_data.zoom_sent)
        else $error("zoom changed without a zoom command");

endmodule

bind autofocus_zoom_controller_unit azc_port_checker u_azc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: tb/azc_checker.sv
// Checker that predicts every frame result of the autofocus and zoom controller and compares it.
`timescale 1ns / 100ps
module azc_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  azc_pkg::azc_in_t    in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  azc_pkg::azc_out_t   out_data,
    input  logic                cfg_write,
    input  azc_pkg::cfg_index_t cfg_index,
    input  logic [9:0]          cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  checked,
    output int                  rescans,
    output int                  lost_jumps
);
    import azc_pkg::*;

    localparam int FRAME_WRAP    = 24;
    localparam int PERIOD_SHORT  = 3;
    localparam int PERIOD_LONG   = 6;
    localparam int RESCAN_MISSES = 15;
    localparam int LOST_MISSES   = 32;
    localparam int MISS_CEILING  = 63;
    localparam int ZOOM_SLOT     = 6;
    localparam int FOCUS_CEILING = 1023;

    // Register copies.
    logic [9:0] lim_lo;
    logic [9:0] lim_hi;
    logic [5:0] climb_stp;
    logic [5:0] scan_stp;
    logic [9:0] size_up;
    logic [9:0] size_dn;
    logic [7:0] zoom_max;
    logic [4:0] zoom_stp;

    // Controller state as the predictor tracks it.
    logic [4:0]  frame_cnt;
    logic        long_per;
    logic        det_now;
    logic        det_prev;
    logic        scan_mode;
    logic        scan_begin;
    logic        dir_far;
    logic        found;
    logic [9:0]  best_pos;
    logic [15:0] best_sharp;
    logic [15:0] sharp_cur;
    logic [15:0] sharp_last;
    logic [16:0] sum_last;
    logic [17:0] size_filt;
    logic [5:0]  misses;
    logic [9:0]  focus_cmd;
    logic [7:0]  zoom_cmd;

    // Focus and zoom commands still owed by the block, oldest first.
    azc_out_t commands_due[$];
    azc_out_t due;

    // Advance the controller by one frame and return the commands it issues.
    function automatic azc_out_t predict_frame(input azc_in_t fr);
        azc_out_t   r;
        logic [7:0] zoom_was;
        logic       focus_told;
        logic       zoom_told;
        logic       rescan;
        int         per;
        int         nxt;
        int         sum2;
        zoom_was   = zoom_cmd;
        focus_told = 1'b0;
        zoom_told  = 1'b0;

        // Per-frame bookkeeping: counter, detection history, filter and miss count.
        frame_cnt  = (int'(frame_cnt) == FRAME_WRAP - 1) ? 5'd0 : frame_cnt + 5'd1;
        det_prev   = det_now;
        det_now    = fr.target_detected;
        sharp_last = (!det_prev && det_now) ? 16'd0 : sharp_cur;
        sharp_cur  = fr.sharpness;
        size_filt  = 18'((4 * int'(size_filt) + 256 * int'(fr.target_size)) / 5);
        if (!det_now)
            misses = (int'(misses) < MISS_CEILING) ? misses + 6'd1 : misses;
        else
            misses = 6'd0;

        // A long loss of the target while climbing forces a fresh scan.
        rescan = (int'(misses) > RESCAN_MISSES) && !scan_mode;
        if (rescan)
        begin
            scan_mode = 1'b1;
            rescans++;
        end

        // Zoom: jump to the top when the target is lost, else track the filtered size.
        if (!det_now)
        begin
            if (int'(misses) > LOST_MISSES)
            begin
                zoom_cmd  = zoom_max;
                zoom_told = 1'b1;
                frame_cnt = 5'd0;
                misses    = 6'd0;
                lost_jumps++;
            end
        end
        else if (int'(frame_cnt) % 8 == ZOOM_SLOT)
        begin
            if (int'(size_filt) > 256 * int'(size_up))
            begin
                nxt       = int'(zoom_cmd) + int'(zoom_stp);
                zoom_cmd  = 8'((nxt < int'(zoom_max)) ? nxt : int'(zoom_max));
                zoom_told = 1'b1;
            end
            else if (int'(size_filt) < 256 * int'(size_dn))
            begin
                zoom_cmd  = (zoom_cmd > 8'(zoom_stp)) ? zoom_cmd - 8'(zoom_stp) : 8'd0;
                zoom_told = 1'b1;
            end
        end
        if (rescan)
            frame_cnt = 5'd0;

        per = long_per ? PERIOD_LONG : PERIOD_SHORT;
        if (scan_mode)
        begin
            // Coarse scan: start at the low limit, then step and remember the sharpest spot.
            if (scan_begin)
            begin
                if (int'(frame_cnt) % per == 0)
                begin
                    found      = 1'b0;
                    best_sharp = 16'd0;
                    long_per   = 1'b1;
                    focus_cmd  = lim_lo;
                    focus_told = 1'b1;
                    scan_begin = 1'b0;
                end
            end
            else if (int'(frame_cnt) % per == 0)
            begin
                long_per = 1'b0;
                if (det_now && sharp_cur > best_sharp)
                begin
                    best_sharp = sharp_cur;
                    best_pos   = focus_cmd;
                    found      = 1'b1;
                end
                // The end test sees the sum before it is saturated.
                nxt = int'(focus_cmd) + int'(scan_stp);
                if (nxt > int'(lim_hi))
                begin
                    if (found)
                    begin
                        nxt       = int'(best_pos);
                        scan_mode = 1'b0;
                        dir_far   = 1'b1;
                    end
                    scan_begin = 1'b1;
                    frame_cnt  = 5'd0;
                end
                focus_cmd  = 10'((nxt > FOCUS_CEILING) ? FOCUS_CEILING : nxt);
                focus_told = 1'b1;
            end
        end
        else if (det_now)
        begin
            // Hill climb on the two-frame sharpness sum; turn around when it drops.
            if (int'(frame_cnt) % per == 0 && det_prev)
            begin
                sum2 = int'(sharp_cur) + int'(sharp_last);
                if (sum2 < int'(sum_last))
                    dir_far = !dir_far;
                nxt = dir_far ? int'(focus_cmd) + int'(climb_stp)
                              : int'(focus_cmd) - int'(climb_stp);
                // Upper limit first, so inverted limits settle on the low one.
                if (nxt > int'(lim_hi))
                    nxt = int'(lim_hi);
                if (nxt < int'(lim_lo))
                    nxt = int'(lim_lo);
                focus_cmd  = 10'(nxt);
                sum_last   = 17'(sum2);
                focus_told = 1'b1;
            end
        end

        r.focus_position = focus_cmd;
        r.focus_sent     = focus_told;
        r.zoom_position  = zoom_cmd;
        r.zoom_sent      = zoom_told;
        r.zoom_changed   = (zoom_cmd != zoom_was);
        r.in_scan        = scan_mode;
        return r;
    endfunction

    // Track register writes, predict accepted frames and check accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_lo     = 10'd650;
            lim_hi     = 10'd800;
            climb_stp  = 6'd3;
            scan_stp   = 6'd10;
            size_up    = 10'd30;
            size_dn    = 10'd25;
            zoom_max   = 8'd171;
            zoom_stp   = 5'd3;
            frame_cnt  = 5'd0;
            long_per   = 1'b0;
            det_now    = 1'b0;
            det_prev   = 1'b0;
            scan_mode  = 1'b1;
            scan_begin = 1'b1;
            dir_far    = 1'b1;
            found      = 1'b0;
            best_pos   = 10'd0;
            best_sharp = 16'd0;
            sharp_cur  = 16'd0;
            sharp_last = 16'd0;
            sum_last   = 17'd0;
            size_filt  = 18'd25600;
            misses     = 6'd0;
            focus_cmd  = 10'd0;
            zoom_cmd   = 8'd171;
            commands_due.delete();
            errors     = 0;
            pending    = 0;
            checked    = 0;
            rescans    = 0;
            lost_jumps = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FOCUS_LOW:      lim_lo    = cfg_data;
                    CFG_FOCUS_HIGH:     lim_hi    = cfg_data;
                    CFG_CLIMB_STEP:     climb_stp = cfg_data[5:0];
                    CFG_SCAN_STEP:      scan_stp  = cfg_data[5:0];
                    CFG_SIZE_UPPER:     size_up   = cfg_data;
                    CFG_SIZE_LOWER:     size_dn   = cfg_data;
                    CFG_ZOOM_TOP:       zoom_max  = cfg_data[7:0];
                    CFG_ZOOM_INCREMENT: zoom_stp  = cfg_data[4:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                commands_due.push_back(predict_frame(in_data));

            if (out_valid && !out_stall)
            begin
                if (commands_due.size() == 0)
                begin
                    errors++;
                    $error("result arrived with no frame outstanding");
                end
                else
                begin
                    due = commands_due.pop_front();
                    checked++;
                    if (out_data.focus_position !== due.focus_position)
                    begin
                        errors++;
                        $error("focus_position: expected %0d, actual %0d",
                               due.focus_position, out_data.focus_position);
                    end
                    if (out_data.focus_sent !== due.focus_sent)
                    begin
                        errors++;
                        $error("focus_sent: expected %0d, actual %0d",
                               due.focus_sent, out_data.focus_sent);
                    end
                    if (out_data.zoom_position !== due.zoom_position)
                    begin
                        errors++;
                        $error("zoom_position: expected %0d, actual %0d",
                               due.zoom_position, out_data.zoom_position);
                    end
                    if (out_data.zoom_sent !== due.zoom_sent)
                    begin
                        errors++;
                        $error("zoom_sent: expected %0d, actual %0d",
                               due.zoom_sent, out_data.zoom_sent);
                    end
                    if (out_data.zoom_changed !== due.zoom_changed)
                    begin
                        errors++;
                        $error("zoom_changed: expected %0d, actual %0d",
                               due.zoom_changed, out_data.zoom_changed);
                    end
                    if (out_data.in_scan !== due.in_scan)
                    begin
                        errors++;
                        $error("in_scan: expected %0d, actual %0d",
                               due.in_scan, out_data.in_scan);
                    end
                end
            end
            pending = commands_due.size();
        end
    end

endmodule

FILE: tb/autofocus_zoom_controller_unit_tb.sv
// Testbench top for the autofocus and zoom controller: frame stimulus, settings and verdict.
`timescale 1ns / 100ps
module autofocus_zoom_controller_unit_tb;
    import azc_pkg::*;

    localparam int MAX_IDLE      = 18;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 20000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    azc_in_t    in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    azc_out_t   out_data;
    logic       cfg_write = 1'b0;
    cfg_index_t cfg_index = CFG_FOCUS_LOW;
    logic [9:0] cfg_data  = '0;

    int errors;
    int pending;
    int checked;
    int rescans;
    int lost_jumps;

    int frames_sent     = 0;
    int settings_loaded = 1;
    bit source_busy     = 1'b0;
    bit hold_requested  = 1'b0;

    // Frame generator state: detection runs, drifting sharpness, size band.
    int sharp_walk    = 20000;
    int size_low_ref  = 25;
    int size_high_ref = 30;
    int run_left      = 0;
    bit run_seen      = 1'b1;

    autofocus_zoom_controller_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    azc_checker frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .rescans    (rescans),
        .lost_jumps (lost_jumps)
    );

    // Clock.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Next random frame: mostly long detected runs, some short and long losses.
    function automatic azc_in_t make_frame();
        azc_in_t fr;
        int      roll;
        int      lo;
        int      hi;
        if (run_left == 0)
        begin
            roll     = $urandom_range(0, 9);
            run_seen = (roll < 7);
            if (run_seen)
                run_left = $urandom_range(1, 90);
            else if (roll == 7)
                run_left = $urandom_range(1, 15);
            else
                run_left = $urandom_range(16, 45);
        end
        run_left--;

        roll = $urandom_range(0, 19);
        fr.target_detected = (roll == 0) ? !run_seen : run_seen;

        if (roll == 1)
            sharp_walk = $urandom_range(0, 65535);
        else
        begin
            sharp_walk = sharp_walk + int'($urandom_range(0, 3000)) - 1500;
            sharp_walk = (sharp_walk < 0) ? 0 : (sharp_walk > 65535) ? 65535 : sharp_walk;
        end
        fr.sharpness = 16'(sharp_walk);

        // Sizes mostly straddle the zoom thresholds, sometimes anywhere.
        if (roll < 5)
            fr.target_size = 10'($urandom);
        else
        begin
            lo = ((size_low_ref < size_high_ref) ? size_low_ref : size_high_ref) - 12;
            hi = ((size_low_ref < size_high_ref) ? size_high_ref : size_low_ref) + 12;
            lo = (lo < 0) ? 0 : lo;
            hi = (hi > 1023) ? 1023 : hi;
            fr.target_size = 10'($urandom_range(lo, hi));
        end
        return fr;
    endfunction

    // Offer one frame after a random gap and wait until it is taken.
    task automatic send_frame(input azc_in_t fr);
        int gap;
        gap = source_busy ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= fr;
        do
            @(posedge clk);
        while (in_stall);
        frames_sent++;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                source_busy = ($urandom_range(0, 2) != 0);
            send_frame(make_frame());
        end
    endtask

    // Stop offering frames and wait until every predicted result has arrived.
    task automatic wait_for_results();
        int spins;
        spins = 0;
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            spins++;
        end
        while (pending != 0 && spins < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [9:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write all eight registers back to back.
    task automatic load_settings(input logic [9:0] flo, input logic [9:0] fhi,
                                 input logic [9:0] climb, input logic [9:0] scan,
                                 input logic [9:0] sup, input logic [9:0] slo,
                                 input logic [9:0] ztop, input logic [9:0] zinc);
        put_reg(CFG_FOCUS_LOW, flo);
        put_reg(CFG_FOCUS_HIGH, fhi);
        put_reg(CFG_CLIMB_STEP, climb);
        put_reg(CFG_SCAN_STEP, scan);
        put_reg(CFG_SIZE_UPPER, sup);
        put_reg(CFG_SIZE_LOWER, slo);
        put_reg(CFG_ZOOM_TOP, ztop);
        put_reg(CFG_ZOOM_INCREMENT, zinc);
        cfg_write     <= 1'b0;
        size_high_ref = sup;
        size_low_ref  = slo;
        settings_loaded++;
    endtask

    // Sensible random limits; unused upper data bits are filled with noise.
    task automatic load_random_settings();
        int lo;
        int hi;
        int sup;
        int slo;
        lo  = $urandom_range(0, 900);
        hi  = lo + int'($urandom_range(30, 200));
        hi  = (hi > 1023) ? 1023 : hi;
        sup = $urandom_range(5, 200);
        slo = sup - int'($urandom_range(0, 5));
        load_settings(10'(lo), 10'(hi),
                      {4'($urandom), 6'($urandom_range(1, 63))},
                      {4'($urandom), 6'($urandom_range(4, 63))},
                      10'(sup), 10'(slo),
                      {2'($urandom), 8'($urandom_range(20, 255))},
                      {5'($urandom), 5'($urandom_range(1, 31))});
    endtask

    // Result side: random stalls per result, calm stretches, one long hold on request.
    initial
    begin : result_sink
        int hold;
        int taken;
        bit sink_busy;
        taken     = 0;
        sink_busy = 1'b0;
        @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                sink_busy = ($urandom_range(0, 2) != 0);
            if (hold_requested)
            begin
                hold           = LONG_HOLD;
                hold_requested = 1'b0;
            end
            else
                hold = sink_busy ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // Frame stimulus and register settings.
    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and alternating bit patterns under the reset settings.
        source_busy = 1'b1;
        send_frame({1'b1, 16'hFFFF, 10'h3FF});
        send_frame({1'b1, 16'h0000, 10'h000});
        send_frame({1'b0, 16'hFFFF, 10'h000});
        send_frame({1'b0, 16'h0000, 10'h3FF});
        send_frame({1'b1, 16'hAAAA, 10'h2AA});
        send_frame({1'b1, 16'h5555, 10'h155});
        // Sharpness rises to a peak and falls away again while the scan runs.
        for (int k = 0; k < 18; k++)
            send_frame({1'b1, 16'(3000 * ((k < 9) ? k : 18 - k)), 10'd28});
        run_random(150);

        // The receiver holds off while frames keep coming, so the block backs up.
        hold_requested = 1'b1;
        source_busy    = 1'b0;
        for (int k = 0; k < 30; k++)
            send_frame(make_frame());
        wait_for_results();

        // Widest focus range, largest steps, thresholds that never trigger.
        load_settings(10'd0, 10'd1023, 10'd63, 10'd63, 10'd1023, 10'd0, 10'd255, 10'd31);
        run_random(120);
        wait_for_results();

        // Inverted focus limits, zero steps, zoom top of zero below the current zoom.
        load_settings(10'd900, 10'd100, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd0, 10'd0);
        run_random(80);
        wait_for_results();

        // The scan steps past the top of the focus range; zoom is capped low.
        load_settings(10'd990, 10'd1020, 10'd7, 10'd63, 10'd30, 10'd25, 10'd20, 10'd31);
        run_random(120);
        wait_for_results();

        // Back to the power-on values.
        load_settings(10'd650, 10'd800, 10'd3, 10'd10, 10'd30, 10'd25, 10'd171, 10'd3);
        run_random(150);
        wait_for_results();

        for (int s = 0; s < 5; s++)
        begin
            load_random_settings();
            run_random(100);
            wait_for_results();
        end

        if (pending != 0)
            $error("%0d results never arrived", pending);
        $display("Sent %0d frames under %0d register settings and compared %0d results.",
                 frames_sent, settings_loaded, checked);
        $display("The run went through %0d rescans and %0d lost-target zoom jumps.",
                 rescans, lost_jumps);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin : watchdog
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
